/* hdl/mpp_pkg.sv */
// Shared types, widths and helpers of the move profile planner.
package mpp_pkg;

  localparam int unsigned POS_W   = 31;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned MOVE_W  = 30;
  localparam int unsigned RAMP_W  = 24;
  localparam int unsigned RATE_W  = 24;
  localparam int unsigned FLOOR_W = 16;
  localparam int unsigned MAG_W   = 31;
  localparam int unsigned SUM_W   = RAMP_W + 1;
  localparam int unsigned DEN_W   = 32;
  localparam int unsigned NUM_W   = 42;
  localparam int unsigned PEAK_W  = 35;
  localparam int unsigned PROD_W  = 45;
  localparam int unsigned WIDE_W  = 36;

  localparam logic [MOVE_W-1:0] MIN_RUN     = MOVE_W'(100);
  localparam logic [10:0]       SPEED_SCALE = 11'd2000;
  localparam logic [9:0]        RATE_SCALE  = 10'd1000;

  localparam logic [1:0] REG_SPEED_LIMIT = 2'd0;
  localparam logic [1:0] REG_ACCEL_LIMIT = 2'd1;
  localparam logic [1:0] REG_DECEL_LIMIT = 2'd2;
  localparam logic [1:0] REG_RATE_FLOOR  = 2'd3;

  localparam logic [RATE_W-1:0]  LIMIT_RST = '1;
  localparam logic [FLOOR_W-1:0] FLOOR_RST = FLOOR_W'(200);

  typedef struct packed {
    logic                     valid;
    logic [NUM_W-1:0]         num;
    logic [DEN_W-1:0]         den;
    logic signed [DIST_W-1:0] delta;
    logic [RAMP_W-1:0]        acc_t;
    logic [RAMP_W-1:0]        dec_t;
  } front_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] delta;
    logic [RAMP_W-1:0]        acc_t;
    logic [RAMP_W-1:0]        dec_t;
  } side1_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] delta;
    logic [PEAK_W-1:0]        peak;
    logic                     sat_a;
    logic                     sat_d;
  } side2_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] delta;
    logic [RATE_W-1:0]        peak;
    logic [RATE_W-1:0]        acc;
    logic [RATE_W-1:0]        dec;
  } result_t;

  function automatic logic [RATE_W-1:0] bound_rate(input logic [WIDE_W-1:0]  x,
                                                   input logic [RATE_W-1:0]  hi,
                                                   input logic [FLOOR_W-1:0] lo);
    logic [RATE_W-1:0] y;
    y = (x > WIDE_W'(hi)) ? hi : x[RATE_W-1:0];
    if (y < RATE_W'(lo)) y = RATE_W'(lo);
    return y;
  endfunction

endpackage

/* hdl/mpp_if.sv */
// Valid/ready channels of the move profile planner.
interface mpp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mpp_pkg::POS_W-1:0]    target_position;
  logic signed [mpp_pkg::POS_W-1:0]    current_position;
  logic [mpp_pkg::MOVE_W-1:0]          move_time_ms;
  logic [mpp_pkg::RAMP_W-1:0]          accel_time_ms;
  logic [mpp_pkg::RAMP_W-1:0]          decel_time_ms;
  modport source(output valid, target_position, current_position, move_time_ms,
                 accel_time_ms, decel_time_ms, input ready);
  modport sink(input valid, target_position, current_position, move_time_ms,
               accel_time_ms, decel_time_ms, output ready);
endinterface

interface mpp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mpp_pkg::DIST_W-1:0]   move_distance;
  logic [mpp_pkg::RATE_W-1:0]          peak_speed;
  logic [mpp_pkg::RATE_W-1:0]          accel_rate;
  logic [mpp_pkg::RATE_W-1:0]          decel_rate;
  modport source(output valid, move_distance, peak_speed, accel_rate, decel_rate,
                 input ready);
  modport sink(input valid, move_distance, peak_speed, accel_rate, decel_rate,
               output ready);
endinterface

/* hdl/move_profile_planner.sv */
// Top level of the trapezoidal move profile planner.
// Usage:
//   in_ch carries one move request per beat (target and current position,
//   move time, accel and decel ramp times). out_ch returns one beat per
//   request: signed distance, peak speed, accel and decel rates, clamped by
//   the limit registers and raised to the floor register.
//   cfg_we/cfg_index/cfg_data write the four registers; write only while idle.
// Pipeline: 3 front stages, a 35-stage divider for the peak speed, 2 rate
//   prep stages, a 24-stage dual-lane divider for the two rates, and the
//   output register.
// Throughput: one beat per cycle, unless stalled, from bit-per-stage dividers.
// Reset: synchronous, clears all valid bits, the output valid and skid full
//   flags, and loads the register defaults (limits all ones, floor 200).
// Stall: while out_ch is held, one more result lands in a skid register;
//   only then does in_ch.ready drop and the whole pipe freeze, and it
//   resumes without loss once the held beat is taken.
module move_profile_planner (
  input  logic                            clk,
  input  logic                            rst_n,
  mpp_in_if.sink                          in_ch,
  mpp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [mpp_pkg::RATE_W-1:0]      cfg_data
);

  logic [mpp_pkg::RATE_W-1:0]  speed_limit_r, accel_limit_r, decel_limit_r;
  logic [mpp_pkg::FLOOR_W-1:0] rate_floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r <= mpp_pkg::LIMIT_RST;
      accel_limit_r <= mpp_pkg::LIMIT_RST;
      decel_limit_r <= mpp_pkg::LIMIT_RST;
      rate_floor_r  <= mpp_pkg::FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mpp_pkg::REG_SPEED_LIMIT: speed_limit_r <= cfg_data;
        mpp_pkg::REG_ACCEL_LIMIT: accel_limit_r <= cfg_data;
        mpp_pkg::REG_DECEL_LIMIT: decel_limit_r <= cfg_data;
        mpp_pkg::REG_RATE_FLOOR:  rate_floor_r  <= cfg_data[mpp_pkg::FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_full_r;
  assign en          = !skid_full_r;
  assign in_ch.ready = en;

  mpp_pkg::front_t front;

  mpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_target (in_ch.target_position),
    .in_current(in_ch.current_position),
    .in_move   (in_ch.move_time_ms),
    .in_acc    (in_ch.accel_time_ms),
    .in_dec    (in_ch.decel_time_ms),
    .out_front (front)
  );

  logic [mpp_pkg::NUM_W-1:0]  d1_num [1];
  logic [mpp_pkg::DEN_W-1:0]  d1_den [1];
  logic [mpp_pkg::PEAK_W-1:0] d1_quo [1];
  mpp_pkg::side1_t            d1_side_in, d1_side_out;
  logic                       d1_valid;

  always_comb begin
    d1_num[0]        = front.num;
    d1_den[0]        = front.den;
    d1_side_in.delta = front.delta;
    d1_side_in.acc_t = front.acc_t;
    d1_side_in.dec_t = front.dec_t;
  end

  mpp_divider #(
    .NW(mpp_pkg::NUM_W), .DW(mpp_pkg::DEN_W), .QW(mpp_pkg::PEAK_W),
    .SW($bits(mpp_pkg::side1_t)), .LANES(1)
  ) u_peak_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (front.valid),
    .in_num   (d1_num),
    .in_den   (d1_den),
    .in_side  (d1_side_in),
    .out_valid(d1_valid),
    .out_quo  (d1_quo),
    .out_side (d1_side_out)
  );

  // rate prep: scale peak, then flag quotients that overflow the field
  logic                              v3_r, v4_r;
  logic [mpp_pkg::PROD_W-1:0]        prod3_r, prod4_r;
  logic [mpp_pkg::PEAK_W-1:0]        peak3_r, peak4_r;
  logic signed [mpp_pkg::DIST_W-1:0] dist3_r, dist4_r;
  logic [mpp_pkg::RAMP_W-1:0]        a3_r, d3_r, a4_r, d4_r;
  logic                              sat_a4_r, sat_d4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v3_r <= d1_valid;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod3_r  <= mpp_pkg::PROD_W'(d1_quo[0]) * mpp_pkg::PROD_W'(mpp_pkg::RATE_SCALE);
      peak3_r  <= d1_quo[0];
      dist3_r  <= d1_side_out.delta;
      a3_r     <= d1_side_out.acc_t;
      d3_r     <= d1_side_out.dec_t;
      prod4_r  <= prod3_r;
      peak4_r  <= peak3_r;
      dist4_r  <= dist3_r;
      a4_r     <= a3_r;
      d4_r     <= d3_r;
      sat_a4_r <= ({3'b000, prod3_r} >= {a3_r, mpp_pkg::RATE_W'(0)});
      sat_d4_r <= ({3'b000, prod3_r} >= {d3_r, mpp_pkg::RATE_W'(0)});
    end
  end

  logic [mpp_pkg::PROD_W-1:0] d2_num [2];
  logic [mpp_pkg::RAMP_W-1:0] d2_den [2];
  logic [mpp_pkg::RATE_W-1:0] d2_quo [2];
  mpp_pkg::side2_t            d2_side_in, d2_side_out;
  logic                       d2_valid;

  always_comb begin
    d2_num[0]        = prod4_r;
    d2_num[1]        = prod4_r;
    d2_den[0]        = a4_r;
    d2_den[1]        = d4_r;
    d2_side_in.delta = dist4_r;
    d2_side_in.peak  = peak4_r;
    d2_side_in.sat_a = sat_a4_r;
    d2_side_in.sat_d = sat_d4_r;
  end

  mpp_divider #(
    .NW(mpp_pkg::PROD_W), .DW(mpp_pkg::RAMP_W), .QW(mpp_pkg::RATE_W),
    .SW($bits(mpp_pkg::side2_t)), .LANES(2)
  ) u_rate_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v4_r),
    .in_num   (d2_num),
    .in_den   (d2_den),
    .in_side  (d2_side_in),
    .out_valid(d2_valid),
    .out_quo  (d2_quo),
    .out_side (d2_side_out)
  );

  mpp_pkg::result_t res_nxt;

  always_comb begin
    res_nxt.delta = d2_side_out.delta;
    res_nxt.peak  = mpp_pkg::bound_rate(mpp_pkg::WIDE_W'(d2_side_out.peak),
                                        speed_limit_r, rate_floor_r);
    res_nxt.acc   = mpp_pkg::bound_rate(
                      mpp_pkg::WIDE_W'({d2_side_out.sat_a, d2_quo[0]}),
                      accel_limit_r, rate_floor_r);
    res_nxt.dec   = mpp_pkg::bound_rate(
                      mpp_pkg::WIDE_W'({d2_side_out.sat_d, d2_quo[1]}),
                      decel_limit_r, rate_floor_r);
  end

  // output register with one-entry skid
  logic              out_valid_r;
  mpp_pkg::result_t  out_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      if (skid_full_r) begin
        out_valid_r <= 1'b1;
        skid_full_r <= 1'b0;
      end else begin
        out_valid_r <= d2_valid;
      end
    end else if (d2_valid && en) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_r <= skid_full_r ? skid_r : res_nxt;
    end else if (d2_valid && en) begin
      skid_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.move_distance = out_r.delta;
  assign out_ch.peak_speed    = out_r.peak;
  assign out_ch.accel_rate    = out_r.acc;
  assign out_ch.decel_rate    = out_r.dec;

endmodule

/* hdl/mpp_front.sv */
// Front stages: distance, ramp fixups, run time, divisor and scaled numerator.
module mpp_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [mpp_pkg::POS_W-1:0]  in_target,
  input  logic signed [mpp_pkg::POS_W-1:0]  in_current,
  input  logic [mpp_pkg::MOVE_W-1:0]        in_move,
  input  logic [mpp_pkg::RAMP_W-1:0]        in_acc,
  input  logic [mpp_pkg::RAMP_W-1:0]        in_dec,
  output mpp_pkg::front_t                   out_front
);

  logic                               v0_r, v1_r, v2_r;
  logic signed [mpp_pkg::DIST_W-1:0]  dist0_r, dist1_r, dist2_r;
  logic [mpp_pkg::RAMP_W-1:0]         a0_r, a1_r, a2_r, d0_r, d1_r, d2_r;
  logic [mpp_pkg::SUM_W-1:0]          ramp0_r, ramp1_r;
  logic [mpp_pkg::MOVE_W-1:0]         move0_r, run1_r;
  logic [mpp_pkg::MAG_W-1:0]          mag1_r;
  logic [mpp_pkg::NUM_W-1:0]          num2_r;
  logic [mpp_pkg::DEN_W-1:0]          den2_r;

  logic [mpp_pkg::RAMP_W-1:0]         a0_nxt, d0_nxt;
  logic signed [mpp_pkg::DIST_W-1:0]  diff_nxt;
  logic signed [mpp_pkg::DIST_W-1:0]  absd_nxt;

  always_comb begin
    a0_nxt   = (in_acc == '0) ? mpp_pkg::RAMP_W'(1) : in_acc;
    d0_nxt   = (in_dec == '0) ? mpp_pkg::RAMP_W'(1) : in_dec;
    diff_nxt = $signed({2'b00, move0_r}) - $signed({7'd0, ramp0_r});
    absd_nxt = dist0_r[mpp_pkg::DIST_W-1] ? -dist0_r : dist0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist0_r <= mpp_pkg::DIST_W'(in_target) - mpp_pkg::DIST_W'(in_current);
      a0_r    <= a0_nxt;
      d0_r    <= d0_nxt;
      ramp0_r <= mpp_pkg::SUM_W'(a0_nxt) + mpp_pkg::SUM_W'(d0_nxt);
      move0_r <= in_move;

      dist1_r <= dist0_r;
      a1_r    <= a0_r;
      d1_r    <= d0_r;
      ramp1_r <= ramp0_r;
      mag1_r  <= absd_nxt[mpp_pkg::MAG_W-1:0];
      run1_r  <= (diff_nxt < $signed(mpp_pkg::DIST_W'(mpp_pkg::MIN_RUN)))
                 ? mpp_pkg::MIN_RUN : diff_nxt[mpp_pkg::MOVE_W-1:0];

      dist2_r <= dist1_r;
      a2_r    <= a1_r;
      d2_r    <= d1_r;
      den2_r  <= mpp_pkg::DEN_W'({run1_r, 1'b0}) + mpp_pkg::DEN_W'(ramp1_r);
      num2_r  <= mpp_pkg::NUM_W'(mag1_r) * mpp_pkg::NUM_W'(mpp_pkg::SPEED_SCALE);
    end
  end

  always_comb begin
    out_front.valid = v2_r;
    out_front.num   = num2_r;
    out_front.den   = den2_r;
    out_front.delta = dist2_r;
    out_front.acc_t = a2_r;
    out_front.dec_t = d2_r;
  end

endmodule

/* hdl/mpp_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, several lanes.
module mpp_divider #(
  parameter int unsigned NW    = 42,
  parameter int unsigned DW    = 32,
  parameter int unsigned QW    = 35,
  parameter int unsigned SW    = 8,
  parameter int unsigned LANES = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num [LANES],
  input  logic [DW-1:0] in_den [LANES],
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo [LANES],
  output logic [SW-1:0] out_side
);

  logic [DW-1:0] rem_r  [QW][LANES];
  logic [QW-1:0] low_r  [QW][LANES];
  logic [DW-1:0] den_r  [QW][LANES];
  logic [SW-1:0] side_r [QW];
  logic [QW-1:0] vld_r;

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [DW-1:0] rem_i   [LANES];
    logic [QW-1:0] low_i   [LANES];
    logic [DW-1:0] den_i   [LANES];
    logic [SW-1:0] side_i;
    logic          v_i;
    logic [DW-1:0] rem_nxt [LANES];
    logic [QW-1:0] low_nxt [LANES];

    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_i[l] = DW'(in_num[l] >> QW);
          low_i[l] = in_num[l][QW-1:0];
          den_i[l] = in_den[l];
        end
        side_i = in_side;
        v_i    = in_valid;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_i[l] = rem_r[s-1][l];
          low_i[l] = low_r[s-1][l];
          den_i[l] = den_r[s-1][l];
        end
        side_i = side_r[s-1];
        v_i    = vld_r[s-1];
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        logic [DW:0] t;
        logic        ge;
        t  = {rem_i[l], low_i[l][QW-1]};
        ge = (t >= {1'b0, den_i[l]});
        rem_nxt[l] = ge ? DW'(t - {1'b0, den_i[l]}) : t[DW-1:0];
        low_nxt[l] = {low_i[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l] <= rem_nxt[l];
          low_r[s][l] <= low_nxt[l];
          den_r[s][l] <= den_i[l];
        end
        side_r[s] <= side_i;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) out_quo[l] = low_r[QW-1][l];
    out_valid = vld_r[QW-1];
    out_side  = side_r[QW-1];
  end

endmodule

/* hdl/mpp_checker.sv */
// Port-level checks of the move profile planner, bound to the top level.
module mpp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [mpp_pkg::DIST_W-1:0] out_dist,
  input logic [mpp_pkg::RATE_W-1:0]        out_peak
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dist) && $stable(out_peak))
    else $error("stalled output beat changed");

  a_backpressure_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  a_ready_returns_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) && $past(rst_n) |-> $past(out_valid && out_ready))
    else $error("input ready returned without an output beat");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && !out_ready |=> !in_ready)
    else $error("input ready returned while output stalled");

endmodule

bind move_profile_planner mpp_checker u_mpp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_dist (out_ch.move_distance),
  .out_peak (out_ch.peak_speed)
);
